// ----- rtl/core/cigar_alignment_scorer_core_assert.svh -----
`ifndef CIGAR_ALIGNMENT_SCORER_CORE_ASSERT_SVH
`define CIGAR_ALIGNMENT_SCORER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CAS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("cas assertion failed");

// Next-cycle implication, checked outside reset.
`define CAS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("cas assertion failed");

`endif

// ----- rtl/core/cas_pkg.sv -----
package cas_pkg;

	localparam logic [2:0] KIND_MATCH     = 3'd0;
	localparam logic [2:0] KIND_MISMATCH  = 3'd1;
	localparam logic [2:0] KIND_INSERTION = 3'd2;
	localparam logic [2:0] KIND_DELETION  = 3'd3;
	localparam logic [2:0] KIND_JUMP      = 3'd4;
	localparam logic [2:0] KIND_CLIPPED   = 3'd5;

	localparam logic [2:0] BASE_A = 3'd0;
	localparam logic [2:0] BASE_C = 3'd1;
	localparam logic [2:0] BASE_G = 3'd2;
	localparam logic [2:0] BASE_T = 3'd3;

	localparam logic [2:0] REG_MATCH_REWARD      = 3'd0;
	localparam logic [2:0] REG_TRANSITION_COST   = 3'd1;
	localparam logic [2:0] REG_TRANSVERSION_COST = 3'd2;
	localparam logic [2:0] REG_GAP_OPEN_COST     = 3'd3;
	localparam logic [2:0] REG_GAP_EXTEND_COST   = 3'd4;
	localparam logic [2:0] REG_JUMP_COST         = 3'd5;
	localparam logic [2:0] REG_START_BONUS       = 3'd6;
	localparam logic [2:0] REG_END_BONUS         = 3'd7;

	localparam int DELTA_W = 10;
	localparam int SCORE_W = 32;

	typedef struct packed {
		logic        [6:0] match_reward;
		logic signed [7:0] transition_cost;
		logic signed [7:0] transversion_cost;
		logic signed [7:0] gap_open_cost;
		logic signed [7:0] gap_extend_cost;
		logic signed [7:0] jump_cost;
		logic        [6:0] start_bonus;
		logic        [6:0] end_bonus;
	} cas_cfg_t;

	// Kind of the previous column and of the column before that run.
	typedef struct packed {
		logic [2:0] prev;
		logic [2:0] prior;
	} kind_hist_t;

	// Unused op codes behave as clipped.
	function automatic logic [2:0] norm_kind(input logic [2:0] op);
		return (op > KIND_CLIPPED) ? KIND_CLIPPED : op;
	endfunction

endpackage

// ----- rtl/core/cas_cfg_regs.sv -----
module cas_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [7:0]        cfg_wdata,
	output cas_pkg::cas_cfg_t cfg
);

	cas_pkg::cas_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.match_reward      <= 7'd2;
			cfg_q.transition_cost   <= -8'sd1;
			cfg_q.transversion_cost <= -8'sd2;
			cfg_q.gap_open_cost     <= -8'sd3;
			cfg_q.gap_extend_cost   <= -8'sd1;
			cfg_q.jump_cost         <= 8'sd0;
			cfg_q.start_bonus       <= 7'd0;
			cfg_q.end_bonus         <= 7'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cas_pkg::REG_MATCH_REWARD:      cfg_q.match_reward      <= cfg_wdata[6:0];
				cas_pkg::REG_TRANSITION_COST:   cfg_q.transition_cost   <= cfg_wdata;
				cas_pkg::REG_TRANSVERSION_COST: cfg_q.transversion_cost <= cfg_wdata;
				cas_pkg::REG_GAP_OPEN_COST:     cfg_q.gap_open_cost     <= cfg_wdata;
				cas_pkg::REG_GAP_EXTEND_COST:   cfg_q.gap_extend_cost   <= cfg_wdata;
				cas_pkg::REG_JUMP_COST:         cfg_q.jump_cost         <= cfg_wdata;
				cas_pkg::REG_START_BONUS:       cfg_q.start_bonus       <= cfg_wdata[6:0];
				cas_pkg::REG_END_BONUS:         cfg_q.end_bonus         <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/cas_delta.sv -----
module cas_delta (
	input  logic [2:0]                           kind,
	input  logic [2:0]                           ref_base,
	input  logic [2:0]                           query_base,
	input  logic                                 first_column,
	input  logic                                 last_column,
	input  cas_pkg::cas_cfg_t                    cfg,
	input  cas_pkg::kind_hist_t                  hist,
	output logic signed [cas_pkg::DELTA_W-1:0]   delta
);

	localparam int EXT = cas_pkg::DELTA_W - 8;
	localparam int ZEXT = cas_pkg::DELTA_W - 7;

	logic signed [cas_pkg::DELTA_W-1:0] match_v;
	logic signed [cas_pkg::DELTA_W-1:0] ts_v;
	logic signed [cas_pkg::DELTA_W-1:0] tv_v;
	logic signed [cas_pkg::DELTA_W-1:0] open_v;
	logic signed [cas_pkg::DELTA_W-1:0] ext_v;
	logic signed [cas_pkg::DELTA_W-1:0] jump_v;
	logic signed [cas_pkg::DELTA_W-1:0] start_v;
	logic signed [cas_pkg::DELTA_W-1:0] end_v;
	logic signed [cas_pkg::DELTA_W-1:0] base_v;
	logic signed [cas_pkg::DELTA_W-1:0] matrix_v;
	logic                               known;

	assign match_v = {{ZEXT{1'b0}}, cfg.match_reward};
	assign ts_v    = {{EXT{cfg.transition_cost[7]}}, cfg.transition_cost};
	assign tv_v    = {{EXT{cfg.transversion_cost[7]}}, cfg.transversion_cost};
	assign open_v  = {{EXT{cfg.gap_open_cost[7]}}, cfg.gap_open_cost};
	assign ext_v   = {{EXT{cfg.gap_extend_cost[7]}}, cfg.gap_extend_cost};
	assign jump_v  = {{EXT{cfg.jump_cost[7]}}, cfg.jump_cost};
	assign start_v = {{ZEXT{1'b0}}, cfg.start_bonus};
	assign end_v   = {{ZEXT{1'b0}}, cfg.end_bonus};

	assign known = (ref_base <= cas_pkg::BASE_T) && (query_base <= cas_pkg::BASE_T);

	// A/G and C/T pairs differ only in the upper code bit.
	always_comb begin
		if (!known)
			matrix_v = tv_v;
		else if (ref_base == query_base)
			matrix_v = match_v;
		else if ((ref_base[1:0] ^ query_base[1:0]) == 2'b10)
			matrix_v = ts_v;
		else
			matrix_v = tv_v;
	end

	always_comb begin
		case (kind)
			cas_pkg::KIND_MATCH, cas_pkg::KIND_MISMATCH: base_v = matrix_v;
			cas_pkg::KIND_INSERTION:
				base_v = (hist.prev == cas_pkg::KIND_INSERTION) ? ext_v : open_v;
			cas_pkg::KIND_DELETION: begin
				// Deletion resumed across a jump run keeps extending.
				if (hist.prev == cas_pkg::KIND_DELETION ||
				    (hist.prev == cas_pkg::KIND_JUMP && hist.prior == cas_pkg::KIND_DELETION))
					base_v = ext_v;
				else
					base_v = open_v;
			end
			cas_pkg::KIND_JUMP:
				base_v = (hist.prev == cas_pkg::KIND_JUMP) ? '0 : jump_v;
			default: base_v = '0;
		endcase
	end

	always_comb begin
		delta = base_v;
		if (kind != cas_pkg::KIND_CLIPPED) begin
			if (first_column)
				delta = delta + start_v;
			if (last_column)
				delta = delta + end_v;
		end
	end

endmodule

// ----- rtl/core/cas_accum.sv -----
module cas_accum (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 fire,
	input  logic [2:0]                           kind,
	input  logic                                 first_column,
	input  logic signed [cas_pkg::DELTA_W-1:0]   delta,
	output cas_pkg::kind_hist_t                  hist,
	output logic signed [cas_pkg::SCORE_W-1:0]   total_next
);

	localparam int SW = cas_pkg::SCORE_W;

	logic signed [SW-1:0] total_q;
	cas_pkg::kind_hist_t  hist_q;
	cas_pkg::kind_hist_t  hist_next;
	logic signed [SW-1:0] total_eff;
	logic signed [SW:0]   sum;

	// A first column starts from a cleared total and clipped history.
	always_comb begin
		if (first_column) begin
			hist.prev  = cas_pkg::KIND_CLIPPED;
			hist.prior = cas_pkg::KIND_CLIPPED;
			total_eff  = '0;
		end else begin
			hist      = hist_q;
			total_eff = total_q;
		end
	end

	always_comb begin
		hist_next = hist;
		if (kind != hist.prev) begin
			hist_next.prior = hist.prev;
			hist_next.prev  = kind;
		end
	end

	assign sum = {total_eff[SW-1], total_eff} +
	             {{(SW + 1 - cas_pkg::DELTA_W){delta[cas_pkg::DELTA_W-1]}}, delta};

	// Clamp on signed overflow.
	always_comb begin
		if (sum[SW] != sum[SW-1])
			total_next = sum[SW] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
		else
			total_next = sum[SW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q      <= '0;
			hist_q.prev  <= cas_pkg::KIND_CLIPPED;
			hist_q.prior <= cas_pkg::KIND_CLIPPED;
		end else if (fire) begin
			total_q <= total_next;
			hist_q  <= hist_next;
		end
	end

endmodule

// ----- rtl/core/cigar_alignment_scorer_core.sv -----
// Alignment column scorer.
// Input channel (in_valid / in_stall) carries one alignment column: op, ref_base,
// query_base and the first_column / last_column marks. Output channel
// (out_valid / out_stall) returns one result per column: column_delta,
// running_score and is_final, in column order.
// A column is captured in an input register; it is then scored against the gap
// history and the running total, and the result loads the result register that
// drives the output channel. One column per cycle is sustained while out_stall
// is low: the score path is a single add and clamp between the two registers.
// When out_stall holds a result, the column waiting in the input register holds
// too and in_stall rises; as soon as the result transfers both advance together.
// cfg_we / cfg_index / cfg_wdata write one scoring register per edge; write them
// only while no column is in flight.
// arst_n clears both valid flags, the running total and the gap history, and
// loads the default scoring values.
`include "cigar_alignment_scorer_core_assert.svh"

module cigar_alignment_scorer_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [2:0]                           cfg_index,
	input  logic [7:0]                           cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [2:0]                           op,
	input  logic [2:0]                           ref_base,
	input  logic [2:0]                           query_base,
	input  logic                                 first_column,
	input  logic                                 last_column,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [cas_pkg::DELTA_W-1:0]   column_delta,
	output logic signed [cas_pkg::SCORE_W-1:0]   running_score,
	output logic                                 is_final
);

	cas_pkg::cas_cfg_t   cfg;
	cas_pkg::kind_hist_t hist;

	logic       valid_s1;
	logic [2:0] kind_s1;
	logic [2:0] ref_s1;
	logic [2:0] query_s1;
	logic       first_s1;
	logic       last_s1;

	logic                               valid_s2;
	logic signed [cas_pkg::DELTA_W-1:0] delta_s2;
	logic signed [cas_pkg::SCORE_W-1:0] score_s2;
	logic                               final_s2;

	logic                               advance;
	logic                               fire;
	logic signed [cas_pkg::DELTA_W-1:0] delta;
	logic signed [cas_pkg::SCORE_W-1:0] total_next;

	assign advance  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	cas_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	cas_delta u_delta (
		.kind         (kind_s1),
		.ref_base     (ref_s1),
		.query_base   (query_s1),
		.first_column (first_s1),
		.last_column  (last_s1),
		.cfg          (cfg),
		.hist         (hist),
		.delta        (delta)
	);

	cas_accum u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.kind         (kind_s1),
		.first_column (first_s1),
		.delta        (delta),
		.hist         (hist),
		.total_next   (total_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Load the column on a transfer.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1  <= cas_pkg::norm_kind(op);
			ref_s1   <= ref_base;
			query_s1 <= query_base;
			first_s1 <= first_column;
			last_s1  <= last_column;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			delta_s2 <= delta;
			score_s2 <= total_next;
			final_s2 <= last_s1;
		end
	end

	assign out_valid     = valid_s2;
	assign column_delta  = delta_s2;
	assign running_score = score_s2;
	assign is_final      = final_s2;

	`CAS_ASSERT_IMP(a_stall_needs_item, clk, arst_n, in_stall, valid_s1)
	`CAS_ASSERT_IMP(a_empty_out_no_stall, clk, arst_n, !valid_s2, !in_stall)
	`CAS_ASSERT_NXT(a_fire_gives_result, clk, arst_n, fire, valid_s2)

endmodule
